/* rtl/dds_tuning_word_command_sequencer_macros.svh */
// Assertion helpers shared by the sequencer RTL.
`ifndef DDS_TUNING_WORD_COMMAND_SEQUENCER_MACROS_SVH
`define DDS_TUNING_WORD_COMMAND_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DDSTW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DDSTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ddstw_pkg.sv */
`default_nettype none

package ddstw_pkg;

   localparam int unsigned TUNING_BITS_DEFAULT = 28;
   localparam int unsigned CHIP_COUNT = 2;

   localparam int unsigned MODULE_WIDTH = 2;
   localparam int unsigned FREQ_WIDTH = 32;
   localparam int unsigned CLOCK_WIDTH = 26;
   localparam int unsigned WORD_WIDTH = 16;
   localparam int unsigned HALF_BITS = 14;
   localparam int unsigned SENT_BITS = 2 * HALF_BITS;

   // Restoring-division steps done in one pipeline stage.
   localparam int unsigned DIV_STEPS_PER_STAGE = 4;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned CSR_INDEX_LSB = 2;
   localparam int unsigned CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - CSR_INDEX_LSB;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REF_CLOCK = '0;
   localparam logic [CLOCK_WIDTH-1:0] REF_CLOCK_RESET = 26'd25000000;

   localparam logic [MODULE_WIDTH-1:0] MODULE_CHIP_ONE = 2'd1;
   localparam logic [MODULE_WIDTH-1:0] MODULE_CHIP_TWO = 2'd2;

   localparam logic [WORD_WIDTH-1:0] WORD_RESET = 16'h0100;
   localparam logic [WORD_WIDTH-1:0] WORD_B28 = 16'h2000;
   localparam logic [WORD_WIDTH-1:0] WORD_FREQ0 = 16'h4000;
   localparam logic [WORD_WIDTH-1:0] WORD_RUN = 16'h0000;

   localparam int unsigned STEP_WIDTH = 3;
   localparam logic [STEP_WIDTH-1:0] STEP_RESET = 3'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_B28 = 3'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_FREQ_LO = 3'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_FREQ_HI = 3'd3;
   localparam logic [STEP_WIDTH-1:0] STEP_RUN = 3'd4;

   typedef struct packed {
      logic valid;
      logic chip;
   } ddstw_ctrl_type;

endpackage

`default_nettype wire

/* rtl/ddstw_ifs.sv */
`default_nettype none

interface ddstw_req_if;
   import ddstw_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [MODULE_WIDTH-1:0] module_number;
   logic [FREQ_WIDTH-1:0]   freq_hz;

   modport source (output valid, output module_number, output freq_hz, input ready);
   modport sink (input valid, input module_number, input freq_hz, output ready);
endinterface

interface ddstw_rsp_if;
   import ddstw_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  chip_select;
   logic [WORD_WIDTH-1:0] spi_word;
   logic                  last_word;

   modport source (output valid, output chip_select, output spi_word, output last_word,
                   input ready);
   modport sink (input valid, input chip_select, input spi_word, input last_word,
                 output ready);
endinterface

`default_nettype wire

/* rtl/ddstw_div_stage.sv */
`default_nettype none

module ddstw_div_stage #(
   parameter int unsigned TUNING_BITS = ddstw_pkg::TUNING_BITS_DEFAULT,
   parameter int unsigned DVD_WIDTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic [ddstw_pkg::CLOCK_WIDTH-1:0] divisor,
   input  ddstw_pkg::ddstw_ctrl_type              src_ctrl,
   input  wire logic [ddstw_pkg::CLOCK_WIDTH:0]   src_rem,
   input  wire logic [DVD_WIDTH-1:0]              src_dvd,
   input  wire logic [TUNING_BITS-1:0]            src_quot,
   output ddstw_pkg::ddstw_ctrl_type              stage_ctrl,
   output logic [ddstw_pkg::CLOCK_WIDTH:0]        stage_rem,
   output logic [DVD_WIDTH-1:0]                   stage_dvd,
   output logic [TUNING_BITS-1:0]                 stage_quot
);
   import ddstw_pkg::*;

   logic                   valid_ff;
   logic                   chip_ff;
   logic [CLOCK_WIDTH:0]   rem_ff, rem_in;
   logic [DVD_WIDTH-1:0]   dvd_ff, dvd_in;
   logic [TUNING_BITS-1:0] quot_ff, quot_in;

   // Per step, shift one dividend bit into the partial remainder and subtract the
   // divisor where it fits; the quotient keeps only its low bits.
   always_comb begin
      rem_in = src_rem;
      dvd_in = src_dvd;
      quot_in = src_quot;
      for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
         rem_in = {rem_in[CLOCK_WIDTH-1:0], dvd_in[DVD_WIDTH-1]};
         dvd_in = {dvd_in[DVD_WIDTH-2:0], 1'b0};
         if (rem_in >= {1'b0, divisor}) begin
            rem_in = rem_in - {1'b0, divisor};
            quot_in = {quot_in[TUNING_BITS-2:0], 1'b1};
         end else begin
            quot_in = {quot_in[TUNING_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= src_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         chip_ff <= src_ctrl.chip;
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
         quot_ff <= quot_in;
      end
   end

   assign stage_ctrl = '{valid: valid_ff, chip: chip_ff};
   assign stage_rem = rem_ff;
   assign stage_dvd = dvd_ff;
   assign stage_quot = quot_ff;

endmodule

`default_nettype wire

/* rtl/ddstw_divider.sv */
`default_nettype none
`include "dds_tuning_word_command_sequencer_macros.svh"

module ddstw_divider #(
   parameter int unsigned TUNING_BITS = ddstw_pkg::TUNING_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ddstw_req_if.sink                              req,
   input  wire logic                              advance,
   input  wire logic [ddstw_pkg::CLOCK_WIDTH-1:0] divisor,
   output ddstw_pkg::ddstw_ctrl_type              out_ctrl,
   output logic [TUNING_BITS-1:0]                 out_quot
);
   import ddstw_pkg::*;

   localparam int unsigned STEPS = FREQ_WIDTH + TUNING_BITS;
   localparam int unsigned STAGES = (STEPS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
   // Leading zeros pad the dividend to a whole number of stages.
   localparam int unsigned DVD_WIDTH = STAGES * DIV_STEPS_PER_STAGE;

   ddstw_ctrl_type         ctrl_s [STAGES+1];
   logic [CLOCK_WIDTH:0]   rem_s  [STAGES+1];
   logic [DVD_WIDTH-1:0]   dvd_s  [STAGES+1];
   logic [TUNING_BITS-1:0] quot_s [STAGES+1];
   logic                   module_ok;

   // A request for a chip that does not exist enters as a bubble.
   assign module_ok = (req.module_number == MODULE_CHIP_ONE ||
                       req.module_number == MODULE_CHIP_TWO) &&
                      (int'(req.module_number) <= int'(CHIP_COUNT));

   assign req.ready = advance;
   assign ctrl_s[0] = '{valid: req.valid && module_ok, chip: ~req.module_number[0]};
   assign rem_s[0] = '0;
   assign dvd_s[0] = DVD_WIDTH'({req.freq_hz, {TUNING_BITS{1'b0}}});
   assign quot_s[0] = '0;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      ddstw_div_stage #(
         .TUNING_BITS(TUNING_BITS),
         .DVD_WIDTH(DVD_WIDTH)
      ) u_stage (
         .clock(clock),
         .reset(reset),
         .advance(advance),
         .divisor(divisor),
         .src_ctrl(ctrl_s[k]),
         .src_rem(rem_s[k]),
         .src_dvd(dvd_s[k]),
         .src_quot(quot_s[k]),
         .stage_ctrl(ctrl_s[k+1]),
         .stage_rem(rem_s[k+1]),
         .stage_dvd(dvd_s[k+1]),
         .stage_quot(quot_s[k+1])
      );
   end

   assign out_ctrl = ctrl_s[STAGES];
   assign out_quot = quot_s[STAGES];

   `DDSTW_ASSERT_NEXT(a_stall_holds, clock, reset, !advance && out_ctrl.valid, out_ctrl.valid && $stable(out_quot) && $stable(out_ctrl.chip), "stalled result changed")
   `DDSTW_ASSERT_NEXT(a_bad_module_dropped, clock, reset, req.valid && req.ready && !module_ok, !ctrl_s[1].valid, "request for missing chip entered pipeline")
   `DDSTW_ASSERT_NEXT(a_good_module_taken, clock, reset, req.valid && req.ready && module_ok, ctrl_s[1].valid && (ctrl_s[1].chip == !$past(req.module_number[0])), "valid request lost or wrong chip")

endmodule

`default_nettype wire

/* rtl/ddstw_seq.sv */
`default_nettype none
`include "dds_tuning_word_command_sequencer_macros.svh"

module ddstw_seq #(
   parameter int unsigned TUNING_BITS = ddstw_pkg::TUNING_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  ddstw_pkg::ddstw_ctrl_type   in_ctrl,
   input  wire logic [TUNING_BITS-1:0] in_quot,
   output logic                        advance,
   ddstw_rsp_if.source                 rsp
);
   import ddstw_pkg::*;

   localparam int unsigned SENT_WIDTH = (TUNING_BITS > SENT_BITS) ? TUNING_BITS : SENT_BITS;

   logic                   busy_ff, busy_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic                   chip_ff;
   logic [TUNING_BITS-1:0] tw_ff;
   logic [SENT_WIDTH-1:0]  tw_wide;
   logic                   load;
   logic                   at_last;

   assign at_last = (step_ff == STEP_RUN);
   // The pipeline may move whenever the sequence buffer is free or its last
   // beat leaves in this cycle.
   assign advance = !busy_ff || (rsp.ready && at_last);
   assign load = advance && in_ctrl.valid;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (load) begin
         busy_in = 1'b1;
         step_in = STEP_RESET;
      end else if (busy_ff && rsp.ready) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_RESET;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chip_ff <= in_ctrl.chip;
         tw_ff <= in_quot;
      end
   end

   assign tw_wide = SENT_WIDTH'(tw_ff);

   always_comb begin
      unique case (step_ff)
         STEP_RESET:   rsp.spi_word = WORD_RESET;
         STEP_B28:     rsp.spi_word = WORD_B28;
         STEP_FREQ_LO: rsp.spi_word = WORD_FREQ0 | WORD_WIDTH'(tw_wide[HALF_BITS-1:0]);
         STEP_FREQ_HI: rsp.spi_word = WORD_FREQ0 |
                                      WORD_WIDTH'(tw_wide[SENT_BITS-1:HALF_BITS]);
         default:      rsp.spi_word = WORD_RUN;
      endcase
   end

   assign rsp.valid = busy_ff;
   assign rsp.chip_select = chip_ff;
   assign rsp.last_word = at_last;

   `DDSTW_ASSERT_NEXT(a_step_advances, clock, reset, busy_ff && rsp.ready && !at_last, busy_ff && (step_ff == $past(step_ff) + 3'd1), "sequence step did not advance")
   `DDSTW_ASSERT_NEXT(a_idle_after_last, clock, reset, busy_ff && rsp.ready && at_last && !in_ctrl.valid, !busy_ff, "sequence did not end after last word")
   `DDSTW_ASSERT_NEXT(a_load_starts, clock, reset, load, busy_ff && (step_ff == STEP_RESET) && (tw_ff == $past(in_quot)), "new sequence did not start cleanly")

endmodule

`default_nettype wire

/* rtl/dds_tuning_word_command_sequencer.sv */
// A request passes through the divider stages into the sequence buffer, which offers the
// first word beat; the other four words follow one per cycle while rsp.ready is high.
// Divider stages queue requests, which enter while the sequence buffer is free or empties.
// Reset (synchronous, active high) empties the divider pipeline and the sequencer and
// loads ref_clock_hz with 25000000.
`default_nettype none

module dds_tuning_word_command_sequencer #(
   parameter int unsigned TUNING_BITS = ddstw_pkg::TUNING_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   ddstw_req_if.sink                                 req,
   ddstw_rsp_if.source                               rsp,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [ddstw_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [ddstw_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [ddstw_pkg::CSR_DATA_WIDTH-1:0]      prdata,
   output logic                                      pready
);
   import ddstw_pkg::*;

   // The tuning word is floor(freq_hz * 2^TUNING_BITS / ref_clock_hz) with
   // only the low TUNING_BITS bits kept. A restoring divider runs over the
   // whole shifted dividend, four quotient bits per pipeline stage, so that
   // the remainder carried into the low quotient bits is exact. A clock of
   // zero makes every trial subtraction succeed, giving an all-ones word.

   logic [CLOCK_WIDTH-1:0]     ref_clock_ff, ref_clock_in;
   logic                       csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   ddstw_ctrl_type             div_ctrl;
   logic [TUNING_BITS-1:0]     div_quot;
   logic                       advance;

   // The user must write the register only while no request is in flight (the block does not
   // enforce this), so the divider stages read it directly instead of carrying a copy.
   assign pready = 1'b1;
   assign csr_index = paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB];
   assign csr_write = psel && penable && pwrite && pready && (csr_index == REG_REF_CLOCK);

   always_comb begin
      ref_clock_in = ref_clock_ff;
      if (csr_write) begin
         ref_clock_in = pwdata[CLOCK_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_clock_ff <= REF_CLOCK_RESET;
      end else begin
         ref_clock_ff <= ref_clock_in;
      end
   end

   // Addresses beyond the one register read as zero.
   assign prdata = (csr_index == REG_REF_CLOCK) ? CSR_DATA_WIDTH'(ref_clock_ff) : '0;

   // The whole pipeline moves together; it holds while the sequencer still
   // has words of the previous request to send, so nothing is lost or sent
   // twice under back-pressure.
   ddstw_divider #(
      .TUNING_BITS(TUNING_BITS)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .req(req),
      .advance(advance),
      .divisor(ref_clock_ff),
      .out_ctrl(div_ctrl),
      .out_quot(div_quot)
   );

   // The sequencer buffers one finished tuning word and sends the reset,
   // B28, two FREQ0 halves and run words, marking the run word as last.
   ddstw_seq #(
      .TUNING_BITS(TUNING_BITS)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .in_ctrl(div_ctrl),
      .in_quot(div_quot),
      .advance(advance),
      .rsp(rsp)
   );

endmodule

`default_nettype wire
